>>> rtl/multivector_gated_activation_assert.svh
// Assertion macros for the gated activation block.
`ifndef MULTIVECTOR_GATED_ACTIVATION_ASSERT_SVH
`define MULTIVECTOR_GATED_ACTIVATION_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define MGA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define MGA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mga_pkg.sv
// Shared types and constants for the gated activation block.
package mga_pkg;

    localparam int BLADES_MAX = 8;
    localparam int SLOTS      = 9;
    localparam logic [3:0] BIAS_SLOT = 4'd8;

    localparam logic CMD_PROC = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef enum logic [1:0] {
        AGG_WSUM = 2'd0,
        AGG_SUM  = 2'd1,
        AGG_MEAN = 2'd2,
        AGG_ZERO = 2'd3
    } comb_mode_t;

    typedef enum logic [1:0] {
        REG_COMB_MODE    = 2'd0,
        REG_KERNEL_COUNT = 2'd1,
        REG_KERNEL_LIST  = 2'd2
    } reg_idx_t;

    localparam logic [3:0]  KCOUNT_RESET = 4'd8;
    localparam logic [23:0] KLIST_RESET  = 24'hFAC688;

    // round(65536/n) for n = 1..8, zero for n = 0 and above 8
    function automatic logic [16:0] recip_q16(input logic [3:0] n);
        logic [16:0] r;
        case (n)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21845;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13107;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9362;
            4'd8:    r = 17'd8192;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/mga_stream_if.sv
// Stream interfaces for input items and result items.
interface mga_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [5:0]         channel;
    logic [3:0]         slot;
    logic signed [15:0] coef_value;
    logic signed [15:0] blade_0;
    logic signed [15:0] blade_1;
    logic signed [15:0] blade_2;
    logic signed [15:0] blade_3;
    logic signed [15:0] blade_4;
    logic signed [15:0] blade_5;
    logic signed [15:0] blade_6;
    logic signed [15:0] blade_7;

    modport source (
        output valid, cmd, channel, slot, coef_value,
        output blade_0, blade_1, blade_2, blade_3, blade_4, blade_5, blade_6, blade_7,
        input  ready
    );
    modport sink (
        input  valid, cmd, channel, slot, coef_value,
        input  blade_0, blade_1, blade_2, blade_3, blade_4, blade_5, blade_6, blade_7,
        output ready
    );
endinterface

interface mga_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_0;
    logic signed [15:0] out_1;
    logic signed [15:0] out_2;
    logic signed [15:0] out_3;
    logic signed [15:0] out_4;
    logic signed [15:0] out_5;
    logic signed [15:0] out_6;
    logic signed [15:0] out_7;

    modport source (
        output valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
        input  ready
    );
    modport sink (
        input  valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
        output ready
    );
endinterface

>>> rtl/mga_sig_rom.sv
// Sigmoid gate table with registered read.
module mga_sig_rom #(
    parameter int ENTRIES = 256,
    localparam int IW = $clog2(ENTRIES)
) (
    input  logic          clk,
    input  logic          en,
    input  logic [IW-1:0] idx,
    output logic [15:0]   gate
);

    // Fixed-point sigmoid at the bin center, exp(-t) from a cubic raised to 2^8.
    function automatic logic [15:0] sig_entry(input int i);
        int          d;
        logic        neg;
        logic [63:0] d_abs, s, s2, s3, u, den, num, q, r;
        d     = 2 * i + 1 - ENTRIES;
        neg   = d < 0;
        d_abs = 64'(neg ? -d : d);
        s     = (d_abs << 27) / ENTRIES;
        s2    = (s * s) >> 32;
        s3    = (s2 * s) >> 32;
        u     = 64'h1_0000_0000 - s + (s2 >> 1) - s3 / 6;
        if (u > 64'hFFFF_FFFF)
            u = 64'hFFFF_FFFF;
        for (int k = 0; k < 8; k++)
            u = (u * u + 64'h8000_0000) >> 32;
        den = 64'h1_0000_0000 + u;
        num = neg ? ((u << 16) + (den >> 1)) : (64'h1_0000_0000_0000 + (den >> 1));
        // long division at elaboration
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], num[b]};
            if (r >= den)
            begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        if (!neg && q > 64'd65535)
            q = 64'd65535;
        return q[15:0];
    endfunction

    logic [15:0] rom [ENTRIES];

    for (genvar gi = 0; gi < ENTRIES; gi++)
    begin : g_rom
        localparam logic [15:0] VAL = sig_entry(gi);
        assign rom[gi] = VAL;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            gate <= rom[idx];
    end

endmodule

>>> rtl/multivector_gated_activation.sv
// Top level: sigmoid-gated multivector activation with per-channel coefficient store.
//
// din carries items: a load item (cmd high) writes one weight (slot 0..7) or the
// bias (slot 8) of a channel and gives no result; a process item (cmd low)
// carries eight Q8.8 blades and gives one result of eight gated blades on dout.
// Both channels hand over an item when valid and ready are high at a clock edge.
// Registers comb_mode, kernel_count and kernel_blade_list sit on the APB port at
// byte addresses 0, 4 and 8; write them only while no item is in flight.
// Throughput: one item per cycle while dout does not stall. A process item's result
// passes through six register stages: coefficient row read, blade select and
// weight multiply, accumulate, argument/index, sigmoid table read, gate
// multiply.
// Coefficients for a channel are one 144-bit row of a single-port memory; a load
// writes its slot lane at acceptance, so a following process sees it directly.
// Each stage holds when the one after it is full and stalled, so a stalled
// receiver fills bubbles first and then drops din.ready.
// Reset clears the registers to their defaults and empties the pipeline; the
// coefficient memory is not cleared and must be loaded before use.
module multivector_gated_activation #(
    parameter int BLADE_COUNT     = 8,
    parameter int CHANNELS        = 64,
    parameter int SIGMOID_ENTRIES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    mga_in_if.sink      din,
    mga_out_if.source   dout,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IW = $clog2(SIGMOID_ENTRIES);
    localparam int NB = mga_pkg::BLADES_MAX;
    localparam int RW = 16 * mga_pkg::SLOTS;

    // ---------------- configuration ----------------
    mga_pkg::comb_mode_t comb_mode_reg;
    logic [3:0]          kcount_reg;
    logic [23:0]         klist_reg;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comb_mode_reg <= mga_pkg::AGG_SUM;
            kcount_reg    <= mga_pkg::KCOUNT_RESET;
            klist_reg     <= mga_pkg::KLIST_RESET;
        end
        else if (cfg_wr)
        begin
            case (mga_pkg::reg_idx_t'(paddr[3:2]))
                mga_pkg::REG_COMB_MODE:    comb_mode_reg <= mga_pkg::comb_mode_t'(pwdata[1:0]);
                mga_pkg::REG_KERNEL_COUNT: kcount_reg    <= pwdata[3:0];
                mga_pkg::REG_KERNEL_LIST:  klist_reg     <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (mga_pkg::reg_idx_t'(paddr[3:2]))
            mga_pkg::REG_COMB_MODE:    prdata = {30'd0, comb_mode_reg};
            mga_pkg::REG_KERNEL_COUNT: prdata = {28'd0, kcount_reg};
            mga_pkg::REG_KERNEL_LIST:  prdata = {8'd0, klist_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // ---------------- handshake / stage enables ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;
    logic in_acc, proc_acc, load_acc;

    assign en6 = !v6_reg || dout.ready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign din.ready  = en1;
    assign dout.valid = v6_reg;

    assign in_acc   = din.valid && din.ready;
    assign proc_acc = in_acc && (din.cmd == mga_pkg::CMD_PROC);
    assign load_acc = in_acc && (din.cmd == mga_pkg::CMD_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= proc_acc;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // ---------------- coefficient memory ----------------
    logic [RW-1:0]  coef_mem [CHANNELS];
    logic [31:0]    ch_ext;
    logic [AW-1:0]  ch_addr;
    logic           ch_ok;
    logic [RW-1:0]  row_reg;

    assign ch_ext  = 32'(din.channel);
    assign ch_addr = ch_ext[AW-1:0];
    assign ch_ok   = ch_ext < 32'(CHANNELS);

    always_ff @(posedge clk)
    begin
        if (load_acc && ch_ok && (din.slot <= mga_pkg::BIAS_SLOT))
            coef_mem[ch_addr][32'(din.slot) * 16 +: 16] <= din.coef_value;
        if (en1)
            row_reg <= coef_mem[ch_addr];
    end

    // ---------------- stage 1: capture ----------------
    logic signed [15:0] blade_in [NB];
    logic signed [15:0] s1_blade_reg [NB];
    logic               s1_chok_reg;

    assign blade_in[0] = din.blade_0;
    assign blade_in[1] = din.blade_1;
    assign blade_in[2] = din.blade_2;
    assign blade_in[3] = din.blade_3;
    assign blade_in[4] = din.blade_4;
    assign blade_in[5] = din.blade_5;
    assign blade_in[6] = din.blade_6;
    assign blade_in[7] = din.blade_7;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_chok_reg <= ch_ok;
            for (int j = 0; j < NB; j++)
                s1_blade_reg[j] <= (j < BLADE_COUNT) ? blade_in[j] : 16'sd0;
        end
    end

    // ---------------- stage 2: select, weight multiply ----------------
    logic [3:0]          cnt;
    logic signed [15:0]  sel [NB];
    logic signed [15:0]  wgt [NB];
    logic signed [19:0]  sum_c;
    logic signed [31:0]  s2_prod_reg [NB];
    logic signed [19:0]  s2_sum_reg;
    logic signed [15:0]  s2_bias_reg;
    logic [3:0]          s2_cnt_reg;
    logic                s2_zero_reg;
    mga_pkg::comb_mode_t s2_mode_reg;
    logic signed [15:0]  s2_blade_reg [NB];

    assign cnt = (kcount_reg > 4'd8) ? 4'd8 : kcount_reg;

    always_comb
    begin
        sum_c = '0;
        for (int k = 0; k < NB; k++)
        begin
            if ((4'(k) < cnt) && (32'(klist_reg[3*k +: 3]) < 32'(BLADE_COUNT)))
                sel[k] = s1_blade_reg[klist_reg[3*k +: 3]];
            else
                sel[k] = 16'sd0;
            wgt[k] = s1_chok_reg ? $signed(row_reg[16*k +: 16]) : 16'sd0;
            sum_c  = sum_c + 20'(sel[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            for (int k = 0; k < NB; k++)
                s2_prod_reg[k] <= sel[k] * wgt[k];
            s2_sum_reg   <= sum_c;
            s2_bias_reg  <= s1_chok_reg ? $signed(row_reg[16*NB +: 16]) : 16'sd0;
            s2_cnt_reg   <= cnt;
            s2_mode_reg  <= comb_mode_reg;
            s2_zero_reg  <= (comb_mode_reg == mga_pkg::AGG_ZERO);
            s2_blade_reg <= s1_blade_reg;
        end
    end

    // ---------------- stage 3: accumulate, mean multiply ----------------
    logic signed [35:0]  wacc_c;
    logic signed [35:0]  s3_wacc_reg;
    logic signed [37:0]  s3_mprod_reg;
    logic signed [19:0]  s3_sum_reg;
    logic                s3_zero_reg;
    mga_pkg::comb_mode_t s3_mode_reg;
    logic signed [15:0]  s3_blade_reg [NB];

    always_comb
    begin
        wacc_c = 36'sd128 + (36'(s2_bias_reg) <<< 8);
        for (int k = 0; k < NB; k++)
            wacc_c = wacc_c + 36'(s2_prod_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_wacc_reg  <= wacc_c;
            s3_mprod_reg <= 38'(s2_sum_reg) * $signed({1'b0, mga_pkg::recip_q16(s2_cnt_reg)})
                            + 38'sd32768;
            s3_sum_reg   <= s2_sum_reg;
            s3_mode_reg  <= s2_mode_reg;
            s3_zero_reg  <= s2_zero_reg;
            s3_blade_reg <= s2_blade_reg;
        end
    end

    // ---------------- stage 4: argument, saturate, table index ----------------
    logic signed [27:0] arg_c;
    logic [11:0]        biased_c;
    logic [31:0]        scaled_c;
    logic [31:0]        idx_full_c;
    logic [IW-1:0]      idx_reg;
    logic               s4_zero_reg;
    logic signed [15:0] s4_blade_reg [NB];

    always_comb
    begin
        case (s3_mode_reg)
            mga_pkg::AGG_WSUM: arg_c = 28'(s3_wacc_reg >>> 8);
            mga_pkg::AGG_MEAN: arg_c = 28'(s3_mprod_reg >>> 16);
            default:           arg_c = 28'(s3_sum_reg);
        endcase
        if (arg_c < -28'sd2048)
            biased_c = 12'd0;
        else if (arg_c > 28'sd2047)
            biased_c = 12'd4095;
        else
            biased_c = 12'(arg_c + 28'sd2048);
        scaled_c   = 32'(biased_c) * 32'(SIGMOID_ENTRIES);
        idx_full_c = scaled_c >> 12;
        if (idx_full_c >= 32'(SIGMOID_ENTRIES))
            idx_full_c = 32'(SIGMOID_ENTRIES - 1);
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            idx_reg      <= idx_full_c[IW-1:0];
            s4_zero_reg  <= s3_zero_reg;
            s4_blade_reg <= s3_blade_reg;
        end
    end

    // ---------------- stage 5: sigmoid table ----------------
    logic [15:0]        gate;
    logic               s5_zero_reg;
    logic signed [15:0] s5_blade_reg [NB];

    mga_sig_rom #(
        .ENTRIES (SIGMOID_ENTRIES)
    ) u_sig_rom (
        .clk  (clk),
        .en   (en5),
        .idx  (idx_reg),
        .gate (gate)
    );

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_zero_reg  <= s4_zero_reg;
            s5_blade_reg <= s4_blade_reg;
        end
    end

    // ---------------- stage 6: gate multiply, output register ----------------
    logic signed [32:0] gprod [NB];
    logic signed [15:0] out_reg [NB];

    always_comb
    begin
        for (int j = 0; j < NB; j++)
            gprod[j] = (33'(s5_blade_reg[j]) * $signed({17'd0, gate}) + 33'sd32768) >>> 16;
    end

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            for (int j = 0; j < NB; j++)
                out_reg[j] <= s5_zero_reg ? 16'sd0 : gprod[j][15:0];
        end
    end

    assign dout.out_0 = out_reg[0];
    assign dout.out_1 = out_reg[1];
    assign dout.out_2 = out_reg[2];
    assign dout.out_3 = out_reg[3];
    assign dout.out_4 = out_reg[4];
    assign dout.out_5 = out_reg[5];
    assign dout.out_6 = out_reg[6];
    assign dout.out_7 = out_reg[7];

    // ---------------- assertions ----------------
`include "multivector_gated_activation_assert.svh"

    `MGA_ASSERT_NEXT(a_only_proc_enters, in_acc, v1_reg == $past(din.cmd == mga_pkg::CMD_PROC), "pipeline entry does not match accepted item kind")
    `MGA_ASSERT_NEXT(a_row_holds, v1_reg && !en2, v1_reg && $stable(row_reg), "coefficient row lost while stage held")
    `MGA_ASSERT_SAME(a_idx_range, v4_reg, 32'(idx_reg) < 32'(SIGMOID_ENTRIES), "sigmoid index out of range")

endmodule

>>> bench/tb_top.sv
// Testbench for the sigmoid-gated multivector activation block.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [15:0] q88_t;

    typedef struct {
        logic       cmd;
        logic [5:0] channel;
        logic [3:0] slot;
        q88_t       coef_value;
        q88_t       blade [8];
    } slice_item_t;

    typedef struct {
        q88_t val [8];
    } gated_t;

    logic clk;
    logic rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mga_in_if  din ();
    mga_out_if dout ();

    multivector_gated_activation dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din.sink),
        .dout    (dout.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [1:0]  cur_mode;
    logic [3:0]  cur_count;
    logic [23:0] cur_list;
    q88_t        coef_mirror [64][9];
    bit          coef_written [64][9];
    logic [15:0] gate_lut [256];

    gated_t gated_q [$];
    int     err_count;
    bit     hold_long;
    int     sink_long_cycles;
    int     rx_wait;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // signed arithmetic shift right rounds toward minus infinity
    function automatic longint floor_div(input longint x, input int s);
        return x >>> s;
    endfunction

    task automatic build_gate_lut();
        longint unsigned ad, s, s2, s3, u, den, g;
        bit neg;
        for (int i = 0; i < 256; i++)
        begin
            neg = (2 * i + 1) < 256;
            ad = neg ? (256 - (2 * i + 1)) : (2 * i + 1 - 256);
            s = (ad << 27) / 256;
            s2 = (s * s) >> 32;
            s3 = (s2 * s) >> 32;
            u = (64'd1 << 32) - s + (s2 >> 1) - s3 / 6;
            if (u > 64'hFFFF_FFFF)
                u = 64'hFFFF_FFFF;
            for (int k = 0; k < 8; k++)
                u = (u * u + (64'd1 << 31)) >> 32;
            den = (64'd1 << 32) + u;
            if (!neg)
            begin
                g = ((64'd1 << 48) + den / 2) / den;
                if (g > 65535)
                    g = 65535;
            end
            else
                g = ((u << 16) + den / 2) / den;
            gate_lut[i] = g[15:0];
        end
    endtask

    function automatic gated_t predict_gated(input slice_item_t it);
        gated_t r;
        int cnt;
        longint sum, wacc, arg, gate, v;
        int b, idx;
        sum = 0;
        wacc = 0;
        if (cur_mode == mga_pkg::AGG_ZERO)
        begin
            foreach (r.val[j])
                r.val[j] = '0;
            return r;
        end
        cnt = (cur_count > 8) ? 8 : cur_count;
        for (int k = 0; k < cnt; k++)
        begin
            b = (cur_list >> (3 * k)) & 7;
            v = it.blade[b];
            sum += v;
            wacc += v * longint'(coef_mirror[it.channel][k]);
        end
        if (cur_mode == mga_pkg::AGG_WSUM)
            arg = floor_div(wacc + longint'(coef_mirror[it.channel][mga_pkg::BIAS_SLOT]) * 256
                            + 128, 8);
        else if (cur_mode == mga_pkg::AGG_SUM)
            arg = sum;
        else
            arg = floor_div(sum * longint'(mga_pkg::recip_q16(cnt[3:0])) + 32768, 16);
        if (arg < -2048)
            arg = -2048;
        if (arg > 2047)
            arg = 2047;
        idx = int'(((arg + 2048) * 256) >> 12);
        gate = gate_lut[idx];
        foreach (r.val[j])
            r.val[j] = q88_t'(floor_div(longint'(it.blade[j]) * gate + 32768, 16));
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        err_count++;
    endtask

    // sender: waits a random gap unless no_gap is set, then offers one item until accepted
    task automatic send_item(input slice_item_t it, input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            din.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din.valid      <= 1'b1;
        din.cmd        <= it.cmd;
        din.channel    <= it.channel;
        din.slot       <= it.slot;
        din.coef_value <= it.coef_value;
        din.blade_0    <= it.blade[0];
        din.blade_1    <= it.blade[1];
        din.blade_2    <= it.blade[2];
        din.blade_3    <= it.blade[3];
        din.blade_4    <= it.blade[4];
        din.blade_5    <= it.blade[5];
        din.blade_6    <= it.blade[6];
        din.blade_7    <= it.blade[7];
        do
            @(posedge clk);
        while (!din.ready);
        if (it.cmd == mga_pkg::CMD_LOAD)
        begin
            if (it.slot < mga_pkg::SLOTS)
            begin
                coef_mirror[it.channel][it.slot] = it.coef_value;
                coef_written[it.channel][it.slot] = 1'b1;
            end
        end
        else
            gated_q.push_back(predict_gated(it));
    endtask

    function automatic slice_item_t rand_process(input int chan);
        slice_item_t it;
        it.cmd = mga_pkg::CMD_PROC;
        it.channel = chan[5:0];
        it.slot = 4'($urandom_range(0, 15));
        it.coef_value = 16'($urandom);
        foreach (it.blade[j])
        begin
            case ($urandom_range(0, 3))
                0: it.blade[j] = 16'($urandom);
                1: it.blade[j] = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
                2: it.blade[j] = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                default: it.blade[j] = $signed(16'($urandom_range(0, 255))) - 16'sd128;
            endcase
        end
        return it;
    endfunction

    function automatic slice_item_t make_load(input int chan, input int sl, input q88_t val);
        slice_item_t it;
        it = rand_process(chan);
        it.cmd = mga_pkg::CMD_LOAD;
        it.slot = sl[3:0];
        it.coef_value = val;
        return it;
    endfunction

    function automatic bit chan_loaded(input int chan);
        for (int s = 0; s < mga_pkg::SLOTS; s++)
            if (!coef_written[chan][s])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic apb_write(input mga_pkg::reg_idx_t idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            mga_pkg::REG_COMB_MODE:    cur_mode = val[1:0];
            mga_pkg::REG_KERNEL_COUNT: cur_count = val[3:0];
            default:                   cur_list = val[23:0];
        endcase
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        din.valid <= 1'b0;
        while (gated_q.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (12) @(posedge clk);
    endtask

    task automatic set_config(input logic [1:0] m, input logic [3:0] c, input logic [23:0] l);
        drain();
        apb_write(mga_pkg::REG_COMB_MODE, {30'd0, m});
        apb_write(mga_pkg::REG_KERNEL_COUNT, {28'd0, c});
        apb_write(mga_pkg::REG_KERNEL_LIST, {8'd0, l});
    endtask

    task automatic load_channel(input int chan, input bit extreme);
        q88_t v;
        for (int s = 0; s < mga_pkg::SLOTS; s++)
        begin
            if (extreme)
                v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            else
                v = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
            send_item(make_load(chan, s, v));
        end
    endtask

    task automatic test_directed();
        slice_item_t it;
        load_channel(0, 1'b1);
        load_channel(63, 1'b0);
        // ignored writes: slot above bias
        send_item(make_load(5, 9, 16'sh1234));
        send_item(make_load(5, 15, 16'sh7FFF));
        for (int m = 0; m < 4; m++)
        begin
            set_config(m[1:0], 4'd8, mga_pkg::KLIST_RESET);
            it = rand_process(0);
            foreach (it.blade[j])
                it.blade[j] = 16'sh7FFF;
            send_item(it);
            foreach (it.blade[j])
                it.blade[j] = 16'sh8000;
            send_item(it);
            send_item(rand_process(63));
        end
        // zero count: bias alone in weighted mode
        set_config(mga_pkg::AGG_WSUM, 4'd0, 24'hFFFFFF);
        send_item(rand_process(0));
        set_config(mga_pkg::AGG_MEAN, 4'd15, 24'd0);
        send_item(rand_process(63));
        set_config(mga_pkg::AGG_MEAN, 4'd0, 24'h000000);
        send_item(rand_process(0));
    endtask

    task automatic test_random_phase(input int n);
        int chan;
        slice_item_t it;
        for (int i = 0; i < n; i++)
        begin
            chan = $urandom_range(0, 63);
            if ($urandom_range(0, 9) == 0 || !chan_loaded(chan))
            begin
                if (!chan_loaded(chan))
                    load_channel(chan, $urandom_range(0, 7) == 0);
                else
                    send_item(make_load(chan, $urandom_range(0, 15), 16'($urandom)));
            end
            else
            begin
                it = rand_process(chan);
                send_item(it, $urandom_range(0, 3) == 0);
            end
        end
    endtask

    task automatic test_random();
        for (int p = 0; p < 8; p++)
        begin
            set_config(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 24'($urandom));
            test_random_phase(140);
        end
    endtask

    task automatic test_backpressure();
        set_config(mga_pkg::AGG_SUM, 4'd8, mga_pkg::KLIST_RESET);
        sink_long_cycles = 60;
        hold_long = 1'b1;
        for (int i = 0; i < 40; i++)
            send_item(rand_process(0), 1'b1);
    endtask

    // receiver: draws a random wait after each accepted item, plus one long hold when asked
    always @(posedge clk or negedge rst_n)
    begin
        int w;
        if (!rst_n)
        begin
            dout.ready <= 1'b0;
            rx_wait    <= 0;
        end
        else if (hold_long)
            dout.ready <= 1'b0;
        else if (dout.valid && dout.ready)
        begin
            w = $urandom_range(0, 7);
            dout.ready <= (w == 0);
            rx_wait    <= (w == 0) ? 0 : w - 1;
        end
        else if (rx_wait > 0)
            rx_wait <= rx_wait - 1;
        else
            dout.ready <= 1'b1;
    end

    initial
    begin
        hold_long = 1'b0;
        sink_long_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                repeat (sink_long_cycles) @(posedge clk);
                hold_long <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        gated_t exp_r;
        q88_t got [8];
        if (rst_n && dout.valid && dout.ready)
        begin
            got = '{dout.out_0, dout.out_1, dout.out_2, dout.out_3,
                    dout.out_4, dout.out_5, dout.out_6, dout.out_7};
            if (gated_q.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                exp_r = gated_q.pop_front();
                foreach (got[j])
                    if (got[j] !== exp_r.val[j])
                        report_mismatch($sformatf("out_%0d got %0d want %0d",
                                                  j, got[j], exp_r.val[j]));
            end
        end
    end

    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        err_count = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        din.valid = 1'b0;
        din.cmd = mga_pkg::CMD_PROC;
        din.channel = '0;
        din.slot = '0;
        din.coef_value = '0;
        din.blade_0 = '0;
        din.blade_1 = '0;
        din.blade_2 = '0;
        din.blade_3 = '0;
        din.blade_4 = '0;
        din.blade_5 = '0;
        din.blade_6 = '0;
        din.blade_7 = '0;
        cur_mode = mga_pkg::AGG_SUM;
        cur_count = mga_pkg::KCOUNT_RESET;
        cur_list = mga_pkg::KLIST_RESET;
        foreach (coef_written[c, s])
        begin
            coef_written[c][s] = 1'b0;
            coef_mirror[c][s] = '0;
        end
        build_gate_lut();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random();
        drain();
        if (err_count == 0 && gated_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
